// ===== design/adaa_fwr_pkg.sv =====
// Shared types and constants of the anti-aliased full-wave rectifier.
package adaa_fwr_pkg;

    // Register field widths and fixed-point layout
    localparam int ALPHA_W    = 17;
    localparam int GAIN_W     = 17;
    localparam int LIMIT_W    = 23;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_BITS  = 16;

    // Unity in Q1.16 for the blend factor
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    // Register reset values
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd0;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 17'd65536;
    localparam logic               AA_RST    = 1'b1;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 23'd16;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA = 2'd0,
        REG_GAIN  = 2'd1,
        REG_AA_ON = 2'd2,
        REG_LIMIT = 2'd3
    } cfg_reg_t;

    // Current register contents
    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [GAIN_W-1:0]  gain;
        logic               aa_on;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PREP,
        OP_SQ,
        OP_MAG,
        OP_DIV,
        OP_FIX,
        OP_MIX,
        OP_SUM,
        OP_GAIN,
        OP_OUT
    } dp_op_t;

    // Command from controller to datapath
    typedef struct packed {
        logic   load;
        dp_op_t op;
    } cmd_t;

endpackage

// ===== design/adaa_fwr_cfg.sv =====
// Configuration register bank of the anti-aliased full-wave rectifier.
module adaa_fwr_cfg
    import adaa_fwr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write and keep only the bits each register holds
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ALPHA: cfg_next.alpha = cfg_data[ALPHA_W-1:0];
                REG_GAIN:  cfg_next.gain  = cfg_data[GAIN_W-1:0];
                REG_AA_ON: cfg_next.aa_on = cfg_data[0];
                REG_LIMIT: cfg_next.limit = cfg_data[LIMIT_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha <= ALPHA_RST;
            cfg_reg.gain  <= GAIN_RST;
            cfg_reg.aa_on <= AA_RST;
            cfg_reg.limit <= LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/adaa_fwr_dp.sv =====
// Datapath: squares, restoring divider, blend and gain of the rectifier.
module adaa_fwr_dp
    import adaa_fwr_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  cmd_t                          cmd,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          use_quot,
    output logic signed [SAMPLE_BITS:0]   sample_out
);

    localparam int W     = SAMPLE_BITS;
    localparam int SQ_W  = 2 * W;
    localparam int CMP_W = (W > LIMIT_W) ? W : LIMIT_W;

    // Stored samples
    logic signed [W-1:0]   last_reg;
    logic signed [W-1:0]   x_reg;
    logic signed [W-1:0]   p_reg;

    // Working registers
    logic signed [W:0]     rect_reg;
    logic [W:0]            den_reg;
    logic [SQ_W-1:0]       sx_reg;
    logic [SQ_W-1:0]       sp_reg;
    logic [W:0]            rem_reg;
    logic [W-1:0]          lo_reg;
    logic                  flip_reg;
    logic signed [W:0]     wet_reg;
    logic signed [W:0]     dry_reg;
    logic signed [W+1:0]   mix_reg;
    logic signed [W:0]     y_reg;
    logic signed [W:0]     out_reg;

    // Sample arithmetic
    logic signed [W:0]     x_wide;
    logic signed [W:0]     p_wide;
    logic signed [W:0]     diff;
    logic signed [W:0]     sum;
    logic [W:0]            diff_abs;
    logic [W:0]            sum_abs;
    logic [W-1:0]          ax;
    logic [W-1:0]          ap;
    logic                  near;
    logic [W-1:0]          rect_prep;

    // Squares and numerator magnitude
    logic [SQ_W-1:0]       sx_next;
    logic [SQ_W-1:0]       sp_next;
    logic [SQ_W-1:0]       mag_next;
    logic                  neg;

    // Divider step
    logic [W+1:0]          trial;
    logic [W+1:0]          den_ext;
    logic                  q_bit;
    logic [W+1:0]          rem_diff;
    logic [W:0]            rem_next;

    // Sign fix, blend and gain
    logic signed [W:0]     quot_next;
    logic [ALPHA_W-1:0]    alpha_sat;
    logic [ALPHA_W-1:0]    dry_coef;
    logic signed [W+18:0]  wet_prod;
    logic signed [W+17:0]  dry_prod;
    logic signed [W+1:0]   mix_next;
    logic signed [W+19:0]  gain_prod;
    logic signed [W+3:0]   gain_sh;
    logic                  fits;
    logic signed [W:0]     y_next;

    // Difference, midpoint and magnitudes of the held samples
    always_comb
    begin
        x_wide    = {x_reg[W-1], x_reg};
        p_wide    = {p_reg[W-1], p_reg};
        diff      = x_wide - p_wide;
        sum       = x_wide + p_wide;
        diff_abs  = diff[W] ? $unsigned(-diff) : $unsigned(diff);
        sum_abs   = sum[W] ? $unsigned(-sum) : $unsigned(sum);
        ax        = x_reg[W-1] ? $unsigned(-x_reg) : $unsigned(x_reg);
        ap        = p_reg[W-1] ? $unsigned(-p_reg) : $unsigned(p_reg);
        near      = CMP_W'(diff_abs[W-1:0]) <= CMP_W'(cfg.limit);
        rect_prep = cfg.aa_on ? sum_abs[W:1] : ax;
    end

    assign use_quot = cfg.aa_on & ~near;

    // Squares of both magnitudes
    assign sx_next = SQ_W'(ax) * SQ_W'(ax);
    assign sp_next = SQ_W'(ap) * SQ_W'(ap);

    // Magnitude and sign of x|x| - p|p|
    always_comb
    begin
        if (x_reg[W-1] != p_reg[W-1])
        begin
            mag_next = sx_reg + sp_reg;
            neg      = x_reg[W-1];
        end
        else if (sx_reg >= sp_reg)
        begin
            mag_next = sx_reg - sp_reg;
            neg      = x_reg[W-1];
        end
        else
        begin
            mag_next = sp_reg - sx_reg;
            neg      = ~x_reg[W-1];
        end
    end

    // One restoring division step: one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, lo_reg[W-1]};
        den_ext  = {1'b0, den_reg};
        q_bit    = trial >= den_ext;
        rem_diff = trial - den_ext;
        rem_next = q_bit ? rem_diff[W:0] : trial[W:0];
    end

    // Signed quotient
    assign quot_next = flip_reg ? -$signed({1'b0, lo_reg}) : $signed({1'b0, lo_reg});

    // Wet and dry products, truncated toward minus infinity
    always_comb
    begin
        alpha_sat = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
        dry_coef  = ALPHA_ONE - alpha_sat;
        wet_prod  = $signed({1'b0, alpha_sat}) * rect_reg;
        dry_prod  = $signed({1'b0, dry_coef}) * x_reg;
        mix_next  = $signed({wet_reg[W], wet_reg}) + $signed({dry_reg[W], dry_reg});
    end

    // Gain product and saturation to the output range
    always_comb
    begin
        gain_prod = $signed({1'b0, cfg.gain}) * mix_reg;
        gain_sh   = gain_prod[W+19:FRAC_BITS];
        fits      = (&gain_sh[W+3:W]) | ~(|gain_sh[W+3:W]);
        if (fits)
        begin
            y_next = gain_sh[W:0];
        end
        else if (gain_sh[W+3])
        begin
            y_next = {1'b1, {W{1'b0}}};
        end
        else
        begin
            y_next = {1'b0, {W{1'b1}}};
        end
    end

    // Previous sample: state that reset clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else if (cmd.load)
        begin
            last_reg <= sample_in;
        end
    end

    // Capture a new transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= sample_in;
            p_reg <= last_reg;
        end
    end

    // Advance the working registers as commanded
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_PREP:
            begin
                rect_reg <= $signed({1'b0, rect_prep});
                den_reg  <= {diff_abs[W-1:0], 1'b0};
            end
            OP_SQ:
            begin
                sx_reg <= sx_next;
                sp_reg <= sp_next;
            end
            OP_MAG:
            begin
                rem_reg  <= {1'b0, mag_next[SQ_W-1:W]};
                lo_reg   <= mag_next[W-1:0];
                flip_reg <= neg ^ diff[W];
            end
            OP_DIV:
            begin
                rem_reg <= rem_next;
                lo_reg  <= {lo_reg[W-2:0], q_bit};
            end
            OP_FIX:
            begin
                rect_reg <= quot_next;
            end
            OP_MIX:
            begin
                wet_reg <= wet_prod[W+FRAC_BITS:FRAC_BITS];
                dry_reg <= dry_prod[W+FRAC_BITS:FRAC_BITS];
            end
            OP_SUM:
            begin
                mix_reg <= mix_next;
            end
            OP_GAIN:
            begin
                y_reg <= y_next;
            end
            OP_OUT:
            begin
                out_reg <= y_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign sample_out = out_reg;

endmodule

// ===== design/adaa_fwr_ctrl.sv =====
// Controller state machine: sequences one sample through the datapath.
module adaa_fwr_ctrl
    import adaa_fwr_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  logic use_quot,
    output cmd_t cmd
);

    localparam int CNT_W = $clog2(SAMPLE_BITS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQ,
        ST_MAG,
        ST_DIV,
        ST_FIX,
        ST_MIX,
        ST_SUM,
        ST_GAIN,
        ST_OUT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = ~out_valid_reg | ~out_stall;

    // Next state, commands and handshake
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & out_stall;
        in_stall       = 1'b1;
        cmd.load       = 1'b0;
        cmd.op         = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = use_quot ? ST_SQ : ST_MIX;
            end
            ST_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.op     = OP_MAG;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == CNT_W'(SAMPLE_BITS - 1))
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIX:
            begin
                cmd.op     = OP_FIX;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.op     = OP_MIX;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op     = OP_SUM;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.op     = OP_GAIN;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hand over the result once the output register is free
                if (out_free)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    in_stall       = 1'b0;
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/adaa_blended_full_wave_rectifier_top.sv =====
// Flow: a loaded transaction runs through PREP, SQ, MAG, DIV, FIX, MIX, SUM, GAIN and OUT;
// when the quotient is not needed PREP goes straight to MIX. DIV is the bit-serial restoring
// divider; OUT waits while out_stall holds the output register. A new sample is taken only in
// IDLE or in the cycle the result moves to the output register.
// Reset: asynchronous, active low; clears the previous sample, the controller and the
// registers to alpha 0, gain 1.0, anti-aliasing on, near-equal limit 16.
module adaa_blended_full_wave_rectifier_top
    import adaa_fwr_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS:0]   sample_out,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    cfg_t cfg;
    cmd_t cmd;
    logic use_quot;

    // Register bank
    adaa_fwr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer
    adaa_fwr_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .use_quot  (use_quot),
        .cmd       (cmd)
    );

    // Arithmetic
    adaa_fwr_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sample_in  (sample_in),
        .use_quot   (use_quot),
        .sample_out (sample_out)
    );

endmodule
